// ----- rtl/fxa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package fxa_pkg;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_LT       = 4'd4,
      OP_LE       = 4'd5,
      OP_GT       = 4'd6,
      OP_GE       = 4'd7,
      OP_EQ       = 4'd8,
      OP_NE       = 4'd9,
      OP_MIN      = 4'd10,
      OP_MAX      = 4'd11,
      OP_INC      = 4'd12,
      OP_DEC      = 4'd13,
      OP_FROM_INT = 4'd14,
      OP_TO_INT   = 4'd15
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_DIV0 = 2'd2
   } status_type;

   localparam logic [31:0] MAX_RAW = 32'h7fff_ffff;
   localparam logic [31:0] MIN_RAW = 32'h8000_0000;

   // everything about an item that does not depend on the fraction width
   typedef struct packed {
      opcode_type  op;
      logic [31:0] res;
      logic        cmp;
      status_type  st;
      logic        neg;
      logic [63:0] prod;
   } tag_type;

endpackage
`default_nettype wire

// ----- rtl/fxa_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface fxa_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  opcode;
   logic signed [31:0] operand_a;
   logic signed [31:0] operand_b;

   modport source (output valid, output opcode, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input opcode, input operand_a, input operand_b,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/fxa_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface fxa_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] result_value;
   logic        compare_true;
   logic [1:0]  status;

   modport source (output valid, output result_value, output compare_true,
                   output status, input ready);
   modport sink   (input valid, input result_value, input compare_true,
                   input status, output ready);
endinterface
`default_nettype wire

// ----- rtl/fxa_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module fxa_front #(
   parameter int FRACTION_BITS = 8,
   parameter int NW = 32 + FRACTION_BITS
) (
   input  wire logic            clock,
   input  wire logic            reset,
   fxa_req_if.sink              req,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output fxa_pkg::tag_type     out_tag,
   output logic [NW-1:0]        out_num,
   output logic [31:0]          out_den
);

   logic             v_ff, v_in;
   fxa_pkg::tag_type tag_ff, tag_in;
   logic [NW-1:0]    num_ff, num_in;
   logic [31:0]      den_ff, den_in;

   logic [31:0]      a, b;
   logic [32:0]      sum33, dif33;
   logic [NW-1:0]    fi;
   logic             fi_fits;
   logic signed [31:0] sh;
   logic [31:0]      mag_a, mag_b;

   assign req.ready = !v_ff || out_ready;
   assign a = req.operand_a;
   assign b = req.operand_b;

   always_comb begin
      sum33   = {a[31], a} + {b[31], b};
      dif33   = {a[31], a} - {b[31], b};
      fi      = {{FRACTION_BITS{a[31]}}, a} << FRACTION_BITS;
      fi_fits = (&fi[NW-1:31]) || !(|fi[NW-1:31]);
      sh      = req.operand_a >>> FRACTION_BITS;
      mag_a   = a[31] ? (32'd0 - a) : a;
      mag_b   = b[31] ? (32'd0 - b) : b;

      tag_in      = '0;
      tag_in.op   = fxa_pkg::opcode_type'(req.opcode);
      tag_in.st   = fxa_pkg::ST_OK;
      tag_in.neg  = a[31] ^ b[31];
      // signed operands, sign-extended to the full 64-bit product
      tag_in.prod = req.operand_a * req.operand_b;
      num_in      = {mag_a, {FRACTION_BITS{1'b0}}};
      den_in      = mag_b;

      case (tag_in.op)
         fxa_pkg::OP_ADD: begin
            if (sum33[32] != sum33[31]) begin
               tag_in.st  = fxa_pkg::ST_OVF;
               tag_in.res = sum33[32] ? fxa_pkg::MIN_RAW : fxa_pkg::MAX_RAW;
            end else begin
               tag_in.res = sum33[31:0];
            end
         end
         fxa_pkg::OP_SUB: begin
            if (dif33[32] != dif33[31]) begin
               tag_in.st  = fxa_pkg::ST_OVF;
               tag_in.res = dif33[32] ? fxa_pkg::MIN_RAW : fxa_pkg::MAX_RAW;
            end else begin
               tag_in.res = dif33[31:0];
            end
         end
         fxa_pkg::OP_DIV: begin
            if (b == 32'd0) tag_in.st = fxa_pkg::ST_DIV0;
         end
         fxa_pkg::OP_LT: tag_in.cmp = req.operand_a <  req.operand_b;
         fxa_pkg::OP_LE: tag_in.cmp = req.operand_a <= req.operand_b;
         fxa_pkg::OP_GT: tag_in.cmp = req.operand_a >  req.operand_b;
         fxa_pkg::OP_GE: tag_in.cmp = req.operand_a >= req.operand_b;
         fxa_pkg::OP_EQ: tag_in.cmp = a == b;
         fxa_pkg::OP_NE: tag_in.cmp = a != b;
         fxa_pkg::OP_MIN: tag_in.res = (req.operand_a > req.operand_b) ? b : a;
         fxa_pkg::OP_MAX: tag_in.res = (req.operand_a < req.operand_b) ? b : a;
         fxa_pkg::OP_INC: begin
            if (a == fxa_pkg::MAX_RAW) begin
               tag_in.st  = fxa_pkg::ST_OVF;
               tag_in.res = fxa_pkg::MAX_RAW;
            end else begin
               tag_in.res = a + 32'd1;
            end
         end
         fxa_pkg::OP_DEC: begin
            if (a == fxa_pkg::MIN_RAW) begin
               tag_in.st  = fxa_pkg::ST_OVF;
               tag_in.res = fxa_pkg::MIN_RAW;
            end else begin
               tag_in.res = a - 32'd1;
            end
         end
         fxa_pkg::OP_FROM_INT: begin
            if (fi_fits) begin
               tag_in.res = fi[31:0];
            end else begin
               tag_in.st  = fxa_pkg::ST_OVF;
               tag_in.res = a[31] ? fxa_pkg::MIN_RAW : fxa_pkg::MAX_RAW;
            end
         end
         fxa_pkg::OP_TO_INT: tag_in.res = sh;
         default: tag_in.res = '0;
      endcase
   end

   assign v_in = req.ready ? req.valid : v_ff;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         tag_ff <= tag_in;
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   assign out_valid = v_ff;
   assign out_tag   = tag_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;

endmodule
`default_nettype wire

// ----- rtl/fxa_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module fxa_div_cell #(
   parameter int NW = 40
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire fxa_pkg::tag_type  in_tag,
   input  wire logic [NW-1:0]     in_num,
   input  wire logic [31:0]       in_den,
   input  wire logic [31:0]       in_rem,
   input  wire logic [NW-1:0]     in_quo,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output fxa_pkg::tag_type       out_tag,
   output logic [NW-1:0]          out_num,
   output logic [31:0]            out_den,
   output logic [31:0]            out_rem,
   output logic [NW-1:0]          out_quo
);

   logic             v_ff, v_in;
   fxa_pkg::tag_type tag_ff;
   logic [NW-1:0]    num_ff, num_in, quo_ff, quo_in;
   logic [31:0]      den_ff, rem_ff, rem_in;
   logic [32:0]      trial;
   logic             take;

   // one restoring step: bring in the next numerator bit, subtract if it fits
   always_comb begin
      trial  = {in_rem, in_num[NW-1]};
      take   = trial >= {1'b0, in_den};
      rem_in = take ? 32'(trial - {1'b0, in_den}) : trial[31:0];
      num_in = in_num << 1;
      quo_in = {in_quo[NW-2:0], take};
   end

   assign in_ready = !v_ff || out_ready;
   assign v_in     = in_ready ? in_valid : v_ff;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         tag_ff <= in_tag;
         num_ff <= num_in;
         den_ff <= in_den;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign out_valid = v_ff;
   assign out_tag   = tag_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;

endmodule
`default_nettype wire

// ----- rtl/fxa_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module fxa_back #(
   parameter int FRACTION_BITS = 8,
   parameter int NW = 32 + FRACTION_BITS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire fxa_pkg::tag_type  in_tag,
   input  wire logic [31:0]       in_den,
   input  wire logic [31:0]       in_rem,
   input  wire logic [NW-1:0]     in_quo,
   fxa_rsp_if.source              rsp
);

   logic        v_ff, v_in;
   logic [31:0] res_ff, res_in;
   logic        cmp_ff;
   logic [1:0]  st_ff, st_in;

   logic [63:0] pm, mag;
   logic [NW:0] qf;
   logic        neg, ovf;

   always_comb begin
      pm  = in_tag.prod[63] ? (64'd0 - in_tag.prod) : in_tag.prod;
      qf  = {1'b0, in_quo} + {{NW{1'b0}}, ({in_rem, 1'b0} >= {1'b0, in_den})};
      if (in_tag.op == fxa_pkg::OP_MUL) begin
         mag = (pm + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
         neg = in_tag.prod[63];
      end else begin
         mag = 64'(qf);
         neg = in_tag.neg;
      end
      ovf = neg ? (mag > 64'h8000_0000) : (mag > 64'h7fff_ffff);

      res_in = in_tag.res;
      st_in  = in_tag.st;
      if (in_tag.op == fxa_pkg::OP_MUL ||
          (in_tag.op == fxa_pkg::OP_DIV && in_tag.st != fxa_pkg::ST_DIV0)) begin
         if (ovf) begin
            st_in  = fxa_pkg::ST_OVF;
            res_in = neg ? fxa_pkg::MIN_RAW : fxa_pkg::MAX_RAW;
         end else begin
            res_in = neg ? (32'd0 - mag[31:0]) : mag[31:0];
         end
      end
   end

   assign in_ready = !v_ff || rsp.ready;
   assign v_in     = in_ready ? in_valid : v_ff;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         res_ff <= res_in;
         cmp_ff <= in_tag.cmp;
         st_ff  <= st_in;
      end
   end

   assign rsp.valid        = v_ff;
   assign rsp.result_value = res_ff;
   assign rsp.compare_true = cmp_ff;
   assign rsp.status       = st_ff;

endmodule
`default_nettype wire

// ----- rtl/fixed_point_alu_q24_8.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | payload                                  | handshake
// req     | in  | opcode, operand_a, operand_b             | valid/ready
// rsp     | out | result_value, compare_true, status       | valid/ready
//
// stages: one front stage, one divider cell per quotient bit
// (32 + FRACTION_BITS cells), one output stage
// one beat per cycle while rsp is ready; all opcodes share one chain so order holds
// each stage moves when the stage after it is empty or moving, so bubbles close up
// synchronous reset clears only the valid bits of the stages
module fixed_point_alu_q24_8 #(
   parameter int FRACTION_BITS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   fxa_req_if.sink   req,
   fxa_rsp_if.source rsp
);

   // numerator width: magnitude of operand_a with the fraction shifted in
   localparam int NW = 32 + FRACTION_BITS;

   // stage k feeds cell k; index NW is the output of the last cell
   logic             valid_s [NW+1];
   logic             ready_s [NW+1];
   fxa_pkg::tag_type tag_s   [NW+1];
   logic [NW-1:0]    num_s   [NW+1];
   logic [31:0]      den_s   [NW+1];
   logic [31:0]      rem_s   [NW+1];
   logic [NW-1:0]    quo_s   [NW+1];

   // operand decode, short ops, multiplier product
   fxa_front #(.FRACTION_BITS(FRACTION_BITS), .NW(NW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (valid_s[0]),
      .out_ready (ready_s[0]),
      .out_tag   (tag_s[0]),
      .out_num   (num_s[0]),
      .out_den   (den_s[0])
   );

   // divider starts from an empty partial remainder
   assign rem_s[0] = '0;
   assign quo_s[0] = '0;

   // row of restoring divider cells, one quotient bit each
   for (genvar k = 0; k < NW; k++) begin : g_cell
      fxa_div_cell #(.NW(NW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_s[k]),
         .in_ready  (ready_s[k]),
         .in_tag    (tag_s[k]),
         .in_num    (num_s[k]),
         .in_den    (den_s[k]),
         .in_rem    (rem_s[k]),
         .in_quo    (quo_s[k]),
         .out_valid (valid_s[k+1]),
         .out_ready (ready_s[k+1]),
         .out_tag   (tag_s[k+1]),
         .out_num   (num_s[k+1]),
         .out_den   (den_s[k+1]),
         .out_rem   (rem_s[k+1]),
         .out_quo   (quo_s[k+1])
      );
   end

   // rounding, sign and saturation for mul and div, output register
   fxa_back #(.FRACTION_BITS(FRACTION_BITS), .NW(NW)) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (valid_s[NW]),
      .in_ready (ready_s[NW]),
      .in_tag   (tag_s[NW]),
      .in_den   (den_s[NW]),
      .in_rem   (rem_s[NW]),
      .in_quo   (quo_s[NW]),
      .rsp      (rsp)
   );

`ifndef SYNTHESIS
   // an accepted beat always lands in the front stage
   a_front_load: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> valid_s[0])
      else $error("accepted beat not held in front stage");

   // divide by zero never carries a value or a compare flag
   a_div0_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == fxa_pkg::ST_DIV0) |->
         (rsp.result_value == 32'sd0 && !rsp.compare_true))
      else $error("divide by zero beat carries data");

   // a true compare result has ok status and zero value
   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.compare_true) |->
         (rsp.status == fxa_pkg::ST_OK && rsp.result_value == 32'sd0))
      else $error("compare beat with value or status");
`endif

endmodule
`default_nettype wire

// ----- dv/fixed_point_alu_q24_8_tb.sv -----
`timescale 1ns / 1ps
module fixed_point_alu_q24_8_tb;
   import fxa_pkg::*;

   localparam int FRAC = 8;
   localparam int LATENCY = FRAC + 34;
   localparam int N_RANDOM = 600;
   localparam longint CYCLE_LIMIT = 200000;

   // one expected result beat
   typedef struct {
      logic [31:0] value;
      logic        cmp;
      logic [1:0]  st;
   } alu_result_t;

   // scoreboard: predicts each accepted request, checks each response beat
   class alu_scoreboard;
      alu_result_t pending[$];
      int errors;
      int checked;

      function longint clamp(longint v, ref logic [1:0] st);
         if (v > 64'sd2147483647) begin
            st = ST_OVF;
            return 64'sd2147483647;
         end
         if (v < -64'sd2147483648) begin
            st = ST_OVF;
            return -64'sd2147483648;
         end
         return v;
      endfunction

      function alu_result_t compute(opcode_type op, logic signed [31:0] a_in,
                                    logic signed [31:0] b_in);
         alu_result_t r;
         longint a, b, p, m, num, den, q;
         logic [1:0] st;
         a = a_in;
         b = b_in;
         st = ST_OK;
         r.value = '0;
         r.cmp = 1'b0;
         case (op)
            OP_ADD: r.value = clamp(a + b, st);
            OP_SUB: r.value = clamp(a - b, st);
            OP_MUL: begin
               p = a * b;
               m = (p < 0) ? -p : p;
               m = (m + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
               r.value = clamp((p < 0) ? -m : m, st);
            end
            OP_DIV: begin
               if (b == 0) begin
                  st = ST_DIV0;
               end else begin
                  num = ((a < 0) ? -a : a) <<< FRAC;
                  den = (b < 0) ? -b : b;
                  q = (2 * num + den) / (2 * den);
                  r.value = clamp(((a < 0) != (b < 0)) ? -q : q, st);
               end
            end
            OP_LT: r.cmp = a < b;
            OP_LE: r.cmp = a <= b;
            OP_GT: r.cmp = a > b;
            OP_GE: r.cmp = a >= b;
            OP_EQ: r.cmp = a == b;
            OP_NE: r.cmp = a != b;
            OP_MIN: r.value = (a > b) ? b : a;
            OP_MAX: r.value = (a < b) ? b : a;
            OP_INC: r.value = clamp(a + 1, st);
            OP_DEC: r.value = clamp(a - 1, st);
            OP_FROM_INT: r.value = clamp(a * (64'sd1 <<< FRAC), st);
            default: r.value = a_in >>> FRAC;
         endcase
         r.st = st;
         return r;
      endfunction

      function void note_request(opcode_type op, logic signed [31:0] a,
                                 logic signed [31:0] b);
         pending.push_back(compute(op, a, b));
      endfunction

      function void check_response(logic [31:0] value, logic cmp, logic [1:0] st);
         alu_result_t e;
         if (pending.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (value !== e.value) begin
            $error("result_value expected %h actual %h", e.value, value);
            errors++;
         end
         if (cmp !== e.cmp) begin
            $error("compare_true expected %b actual %b", e.cmp, cmp);
            errors++;
         end
         if (st !== e.st) begin
            $error("status expected %0d actual %0d", e.st, st);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   longint cycles = 0;
   bit quiet = 1'b0;          // no idling in the final stretch
   int op_seen[16];

   fxa_req_if req();
   fxa_rsp_if rsp();

   fixed_point_alu_q24_8 #(.FRACTION_BITS(FRAC)) DUT (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   alu_scoreboard board = new();

   always #5 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.opcode = '0;
      req.operand_a = '0;
      req.operand_b = '0;
      rsp.ready = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // check response beats at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         board.check_response(rsp.result_value, rsp.compare_true, rsp.status);
   end

   // sink side stalls in random bursts
   initial begin : sink_stalls
      int n;
      @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp.ready = 1'b0;
            n = $urandom_range(1, 11);
            repeat (n) @(negedge clock);
         end else begin
            rsp.ready = 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) @(negedge clock);
         end
      end
   end

   // present one request beat, wait until accepted; drive at falling edge
   task automatic send_beat(opcode_type op, logic [31:0] a, logic [31:0] b);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req.valid = 1'b0;
         gap = $urandom_range(1, 11);
         repeat (gap) @(negedge clock);
      end
      req.valid = 1'b1;
      req.opcode = op;
      req.operand_a = a;
      req.operand_b = b;
      do @(posedge clock); while (!req.ready);
      board.note_request(op, a, b);
      op_seen[op]++;
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid = 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   // operand biased toward edges and small fixed-point values
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return MAX_RAW - $urandom_range(0, 2);
         1: return MIN_RAW + $urandom_range(0, 2);
         2: return 32'(int'($urandom_range(0, 8)) - 4);
         3: return 32'(int'($urandom_range(0, 4096)) - 2048);
         4: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
         default: return $urandom();
      endcase
   endfunction

   initial begin : stimulus
      opcode_type op;
      logic [31:0] a, b;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, each opcode, saturation and divide by zero
      send_beat(OP_ADD, MAX_RAW, 32'd1);
      send_beat(OP_SUB, MIN_RAW, 32'd1);
      send_beat(OP_MUL, MAX_RAW, MAX_RAW);
      send_beat(OP_MUL, MIN_RAW, MAX_RAW);
      send_beat(OP_MUL, 32'h0000_0180, 32'hffff_ff80);   // negative product, exact in Q24.8
      send_beat(OP_DIV, 32'h0000_0100, 32'd0);
      send_beat(OP_DIV, MIN_RAW, 32'hffff_ffff);
      send_beat(OP_DIV, 32'h0000_0100, 32'h0000_0300);
      send_beat(OP_DIV, 32'hffff_ff00, 32'h0000_0200);
      send_beat(OP_LT, MIN_RAW, MAX_RAW);
      send_beat(OP_LE, 32'd5, 32'd5);
      send_beat(OP_GT, MIN_RAW, MAX_RAW);
      send_beat(OP_GE, MAX_RAW, MAX_RAW);
      send_beat(OP_EQ, 32'hffff_ffff, 32'hffff_ffff);
      send_beat(OP_NE, 32'd0, 32'd1);
      send_beat(OP_MIN, MIN_RAW, MAX_RAW);
      send_beat(OP_MAX, MIN_RAW, MAX_RAW);
      send_beat(OP_INC, MAX_RAW, 32'd0);
      send_beat(OP_DEC, MIN_RAW, 32'hffff_ffff);
      send_beat(OP_FROM_INT, 32'h0080_0000, 32'd0);
      send_beat(OP_FROM_INT, 32'hff7f_ffff, 32'd0);
      send_beat(OP_TO_INT, 32'hffff_ffff, 32'd0);
      send_beat(OP_TO_INT, MAX_RAW, 32'd0);

      // hold off until the pipe has emptied once
      drain();

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM * 4 / 5)
            quiet = 1'b1;
         op = opcode_type'($urandom_range(0, 15));
         a = pick_operand();
         b = ($urandom_range(0, 15) == 0) ? 32'd0 : pick_operand();
         send_beat(op, a, b);
      end
      drain();
      repeat (LATENCY + 10) @(negedge clock);

      $display("checked %0d results over all 16 opcodes (div ops sent: %0d)",
               board.checked, op_seen[OP_DIV]);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- fixed_point_alu_q24_8.f -----
rtl/fxa_pkg.sv
rtl/fxa_req_if.sv
rtl/fxa_rsp_if.sv
rtl/fxa_front.sv
rtl/fxa_div_cell.sv
rtl/fxa_back.sv
rtl/fixed_point_alu_q24_8.sv
dv/fixed_point_alu_q24_8_tb.sv
